@@ rtl/core/crpq_pkg.sv @@
`default_nettype none

package crpq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PAYLOAD_BYTES_DEF = 6;

  localparam int ADDR_W    = 14;
  localparam int KIND_W    = 4;
  localparam int RPT_W     = 8;
  localparam int PAYLOAD_W = 48;
  localparam int LEN_W     = 3;
  localparam int CMD_W     = 2;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_FORGET = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Mode code 3 is undefined and behaves as plain mode.
  localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EMERG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]    address;
    logic                 addr_kind;
    logic [KIND_W-1:0]    kind;
    logic [RPT_W-1:0]     rpt;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     len;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    WR_ITEM,
    WR_FORGET,
    WR_REPEAT
  } wr_sel_e;

  typedef struct packed {
    logic    load_item;
    logic    scan_start;
    logic    step;
    logic    rd_en;
    logic    wr_en;
    logic    wr_tail;
    wr_sel_e wr_sel;
    logic    push;
    logic    pop;
    logic    set_ok;
    logic    got_load;
    logic    item_from_got;
    logic    clear_q;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [MODE_W-1:0] mode;
    logic              count_zero;
    logic              rpt_zero;
    logic              scan_done;
    logic              full;
    logic              ins_match;
    logic              fgt_match;
    logic              rpt_new_zero;
    logic              out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

@@ rtl/core/crpq_ram.sv @@
`default_nettype none

module crpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/crpq_datapath.sv @@
`default_nettype none

module crpq_datapath #(
  parameter int DEPTH         = crpq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BYTES = crpq_pkg::PAYLOAD_BYTES_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [crpq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [crpq_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic [crpq_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic [crpq_pkg::ADDR_W-1:0]       address_i,
  input  wire logic                              addr_kind_i,
  input  wire logic [crpq_pkg::KIND_W-1:0]       pkt_kind_i,
  input  wire logic [crpq_pkg::RPT_W-1:0]        repeat_count_i,
  input  wire logic [crpq_pkg::PAYLOAD_W-1:0]    payload_i,
  input  wire logic [crpq_pkg::LEN_W-1:0]        payload_len_i,
  input  wire crpq_pkg::ctrl_cmd_t               ctrl_i,
  output crpq_pkg::ctrl_status_t                 status_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   ok_o,
  output logic [crpq_pkg::ADDR_W-1:0]            out_address_o,
  output logic                                   out_addr_kind_o,
  output logic [crpq_pkg::KIND_W-1:0]            out_kind_o,
  output logic [crpq_pkg::RPT_W-1:0]             out_repeat_o,
  output logic [crpq_pkg::PAYLOAD_W-1:0]         out_payload_o,
  output logic [crpq_pkg::LEN_W-1:0]             out_payload_len_o,
  output logic [CNT_W-1:0]                       occupancy_o
);

  import crpq_pkg::*;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int PB_BITS = 8 * PAYLOAD_BYTES;
  localparam logic [PAYLOAD_W-1:0] PMASK = (PB_BITS >= PAYLOAD_W) ? {PAYLOAD_W{1'b1}} :
                                           ((PAYLOAD_W'(1) << PB_BITS) - PAYLOAD_W'(1));
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PAYLOAD_BYTES);

  logic [MODE_W-1:0] mode_q;
  logic [CFG_W-1:0]  size_q;
  logic [KIND_W-1:0] null_q;
  logic [IDX_W-1:0]  head_q, tail_q, i_q;
  logic [CNT_W-1:0]  count_q, k_q;
  cmd_e              cmd_q;
  slot_t             item_q, got_q, out_q;
  logic              ok_q, out_ok_q, out_valid_q;
  logic [CNT_W-1:0]  out_occ_q;

  logic [CNT_W-1:0]  size_eff;
  slot_t             in_slot, rdata, upd, fgt, wdata;
  logic [RPT_W-1:0]  rpt_new;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(idx) + CNT_W'(1);
    return (nxt == n) ? '0 : IDX_W'(nxt);
  endfunction

  always_comb begin
    if (size_q == '0) begin
      size_eff = CNT_W'(1);
    end else if (int'(size_q) > DEPTH) begin
      size_eff = CNT_W'(DEPTH);
    end else begin
      size_eff = CNT_W'(size_q);
    end
  end

  always_comb begin
    in_slot.address   = address_i;
    in_slot.addr_kind = addr_kind_i;
    in_slot.kind      = pkt_kind_i;
    in_slot.rpt       = repeat_count_i;
    in_slot.payload   = payload_i & PMASK;
    in_slot.len       = (int'(payload_len_i) > PAYLOAD_BYTES) ? LEN_MAX : payload_len_i;
  end

  // Repeat mode saturates at zero; emergency mode wraps.
  always_comb begin
    case (mode_q)
      MODE_REPEAT: rpt_new = (rdata.rpt == '0) ? '0 : rdata.rpt - RPT_W'(1);
      MODE_EMERG:  rpt_new = rdata.rpt - RPT_W'(1);
      default:     rpt_new = rdata.rpt;
    endcase
    upd      = rdata;
    upd.rpt  = rpt_new;
    fgt      = rdata;
    fgt.kind = null_q;
    case (ctrl_i.wr_sel)
      WR_ITEM:   wdata = item_q;
      WR_FORGET: wdata = fgt;
      WR_REPEAT: wdata = upd;
      default:   wdata = item_q;
    endcase
  end

  crpq_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.wr_en),
    .waddr_i(ctrl_i.wr_tail ? tail_q : i_q),
    .wdata_i(wdata),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(i_q),
    .rdata_o(rdata)
  );

  always_comb begin
    status_o.cmd          = cmd_q;
    status_o.mode         = mode_q;
    status_o.count_zero   = (count_q == '0);
    status_o.rpt_zero     = (item_q.rpt == '0);
    status_o.scan_done    = (k_q == count_q);
    status_o.full         = (count_q >= size_eff);
    status_o.ins_match    = (rdata.address == item_q.address) && (rdata.kind == item_q.kind);
    status_o.fgt_match    = (rdata.address == item_q.address) &&
                            (rdata.addr_kind == item_q.addr_kind);
    status_o.rpt_new_zero = (rpt_new == '0);
    status_o.out_free     = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_PLAIN;
      size_q      <= CFG_W'(10);
      null_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clear_q) begin
        head_q  <= '0;
        tail_q  <= '0;
        count_q <= '0;
      end else if (ctrl_i.pop) begin
        head_q  <= idx_inc(head_q, size_eff);
        count_q <= count_q - CNT_W'(1);
      end else if (ctrl_i.push) begin
        tail_q  <= idx_inc(tail_q, size_eff);
        count_q <= count_q + CNT_W'(1);
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
          CFG_SIZE: begin
            size_q  <= cfg_data_i;
            head_q  <= '0;
            tail_q  <= '0;
            count_q <= '0;
          end
          CFG_NULL: null_q <= cfg_data_i[KIND_W-1:0];
          default: ;
        endcase
      end
      if (ctrl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      cmd_q  <= cmd_e'(cmd_i);
      item_q <= in_slot;
      ok_q   <= 1'b0;
      got_q  <= '0;
    end
    if (ctrl_i.set_ok) begin
      ok_q <= 1'b1;
    end
    if (ctrl_i.got_load) begin
      got_q <= upd;
    end
    if (ctrl_i.item_from_got) begin
      item_q <= upd;
    end
    if (ctrl_i.scan_start) begin
      i_q <= head_q;
      k_q <= '0;
    end else if (ctrl_i.step) begin
      i_q <= idx_inc(i_q, size_eff);
      k_q <= k_q + CNT_W'(1);
    end
    if (ctrl_i.load_out) begin
      out_q     <= got_q;
      out_ok_q  <= ok_q;
      out_occ_q <= count_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ok_o              = out_ok_q;
  assign out_address_o     = out_q.address;
  assign out_addr_kind_o   = out_q.addr_kind;
  assign out_kind_o        = out_q.kind;
  assign out_repeat_o      = out_q.rpt;
  assign out_payload_o     = out_q.payload;
  assign out_payload_len_o = out_q.len;
  assign occupancy_o       = out_occ_q;

endmodule

`default_nettype wire

@@ rtl/core/crpq_ctrl.sv @@
`default_nettype none

module crpq_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire crpq_pkg::ctrl_status_t status_i,
  output crpq_pkg::ctrl_cmd_t         ctrl_o
);

  import crpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CK,
    S_HEAD_RD,
    S_HEAD_CK,
    S_REINS,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    ctrl_o.wr_sel = WR_ITEM;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_item = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.cmd)
          CMD_INSERT: begin
            if (status_i.mode == MODE_REPEAT && status_i.rpt_zero) begin
              state_d = S_FINISH;
            end else begin
              ctrl_o.scan_start = 1'b1;
              state_d = S_SCAN_RD;
            end
          end
          CMD_READ: begin
            if (status_i.count_zero) begin
              state_d = S_FINISH;
            end else begin
              ctrl_o.scan_start = 1'b1;
              state_d = S_HEAD_RD;
            end
          end
          CMD_FORGET: begin
            ctrl_o.scan_start = 1'b1;
            state_d = S_SCAN_RD;
          end
          default: begin
            ctrl_o.clear_q = 1'b1;
            ctrl_o.set_ok  = 1'b1;
            state_d = S_FINISH;
          end
        endcase
      end
      S_SCAN_RD: begin
        if (status_i.scan_done) begin
          // No coalescing match: append at the tail if there is room.
          if (status_i.cmd != CMD_FORGET && !status_i.full) begin
            ctrl_o.wr_en   = 1'b1;
            ctrl_o.wr_tail = 1'b1;
            ctrl_o.push    = 1'b1;
            ctrl_o.set_ok  = 1'b1;
          end
          state_d = S_FINISH;
        end else begin
          ctrl_o.rd_en = 1'b1;
          state_d = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (status_i.cmd == CMD_FORGET) begin
          if (status_i.fgt_match) begin
            ctrl_o.wr_en  = 1'b1;
            ctrl_o.wr_sel = WR_FORGET;
            ctrl_o.set_ok = 1'b1;
          end
          ctrl_o.step = 1'b1;
          state_d = S_SCAN_RD;
        end else if (status_i.ins_match) begin
          ctrl_o.wr_en  = 1'b1;
          ctrl_o.set_ok = 1'b1;
          state_d = S_FINISH;
        end else begin
          ctrl_o.step = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_HEAD_RD: begin
        ctrl_o.rd_en = 1'b1;
        state_d = S_HEAD_CK;
      end
      S_HEAD_CK: begin
        ctrl_o.got_load = 1'b1;
        ctrl_o.set_ok   = 1'b1;
        state_d = S_FINISH;
        case (status_i.mode)
          MODE_REPEAT: begin
            ctrl_o.pop = 1'b1;
            if (!status_i.rpt_new_zero) begin
              ctrl_o.item_from_got = 1'b1;
              state_d = S_REINS;
            end
          end
          MODE_EMERG: begin
            if (status_i.rpt_new_zero) begin
              ctrl_o.pop = 1'b1;
            end else begin
              ctrl_o.wr_en  = 1'b1;
              ctrl_o.wr_sel = WR_REPEAT;
            end
          end
          default: ctrl_o.pop = 1'b1;
        endcase
      end
      S_REINS: begin
        ctrl_o.scan_start = 1'b1;
        state_d = S_SCAN_RD;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/coalescing_repeat_packet_queue.sv @@
// Coalescing packet queue with plain, repeat and emergency read modes.
// Input channel (in_valid_i/in_ready_o) carries one command transaction:
// insert, read, forget or clear, with the packet fields. Each command
// produces exactly one result transaction on the output channel
// (out_valid_o/out_ready_i): ok flag, delivered packet (zero unless a read
// delivered one) and the occupancy after the command.
// The configuration channel (cfg_valid_i/cfg_ready_o) is always ready. The
// user must write it only while the queue is idle; the block does not
// enforce this. Writing queue_size empties it. One command is worked at a
// time. Entries live in a single-port-write RAM with a registered read, so
// the coalescing and forget scans read and then check each occupied entry
// in turn, and a repeat-mode read adds a re-insert scan after the head read.
// A new command is taken while the previous result still waits in the output
// register; if the receiver stalls, the block holds its finished result
// until the output register frees and accepts nothing more meanwhile.
// Reset empties the queue and loads mode plain, size 10, null kind 0; the
// RAM contents are not cleared, as only occupied slots are ever read.
`default_nettype none

module coalescing_repeat_packet_queue #(
  parameter int DEPTH         = crpq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BYTES = crpq_pkg::PAYLOAD_BYTES_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [crpq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [crpq_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [crpq_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [crpq_pkg::ADDR_W-1:0]    address_i,
  input  wire logic                           addr_kind_i,
  input  wire logic [crpq_pkg::KIND_W-1:0]    pkt_kind_i,
  input  wire logic [crpq_pkg::RPT_W-1:0]     repeat_count_i,
  input  wire logic [crpq_pkg::PAYLOAD_W-1:0] payload_i,
  input  wire logic [crpq_pkg::LEN_W-1:0]     payload_len_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                ok_o,
  output logic [crpq_pkg::ADDR_W-1:0]         out_address_o,
  output logic                                out_addr_kind_o,
  output logic [crpq_pkg::KIND_W-1:0]         out_kind_o,
  output logic [crpq_pkg::RPT_W-1:0]          out_repeat_o,
  output logic [crpq_pkg::PAYLOAD_W-1:0]      out_payload_o,
  output logic [crpq_pkg::LEN_W-1:0]          out_payload_len_o,
  output logic [CNT_W-1:0]                    occupancy_o
);

  import crpq_pkg::*;

  ctrl_cmd_t    ctrl;
  ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  crpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .ctrl_o    (ctrl)
  );

  crpq_datapath #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd_i),
    .address_i        (address_i),
    .addr_kind_i      (addr_kind_i),
    .pkt_kind_i       (pkt_kind_i),
    .repeat_count_i   (repeat_count_i),
    .payload_i        (payload_i),
    .payload_len_i    (payload_len_i),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .ok_o             (ok_o),
    .out_address_o    (out_address_o),
    .out_addr_kind_o  (out_addr_kind_o),
    .out_kind_o       (out_kind_o),
    .out_repeat_o     (out_repeat_o),
    .out_payload_o    (out_payload_o),
    .out_payload_len_o(out_payload_len_o),
    .occupancy_o      (occupancy_o)
  );

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(occupancy_o) <= DEPTH))
    else $error("occupancy exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |-> !status.count_zero)
    else $error("pop from an empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |-> (!status.full && !ctrl.pop))
    else $error("push into a full queue or together with pop");

  a_busy_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.wr_en || ctrl.rd_en) |-> !in_ready_o)
    else $error("RAM access while accepting a command");
`endif

endmodule

`default_nettype wire
